/* hw/rtl/bffa_pkg.sv */
package bffa_pkg;

  localparam int GRANULES = 1024;
  localparam int CELL_W   = 8;
  localparam int CELLS    = GRANULES / CELL_W;
  localparam int GW       = $clog2(GRANULES);
  localparam int CW       = $clog2(CELLS);
  localparam int CNT_W    = GW + 1;
  localparam int POS_W    = CNT_W + 1;
  localparam int ADDR_W   = 13;
  localparam int REQ_W    = 16;
  localparam int NEED_W   = REQ_W - 1;
  localparam logic [ADDR_W-1:0] RegionReset = ADDR_W'(4096);

  typedef struct packed {
    logic              mode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic              failed;
    logic [ADDR_W-1:0] granted_address;
  } rsp_t;

  // scan token passed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [CNT_W-1:0] cnt;
    logic [GW-1:0]    start;
  } token_t;

  // range write broadcast to every cell: granules in [lo, hi) take set
  typedef struct packed {
    logic             en;
    logic             set;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_e;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

endpackage

/* hw/rtl/bffa_cell.sv */
module bffa_cell
  import bffa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CW-1:0]    index_i,
  input  logic [CNT_W-1:0] need_i,
  input  token_t           tok_i,
  output token_t           tok_o,
  input  upd_t             upd_i
);

  logic [CELL_W-1:0] bits_q, bits_d;
  token_t            tok_q, tok_d;

  always_comb begin
    logic [GW-1:0] g;
    tok_d = tok_i;
    for (int j = 0; j < CELL_W; j++) begin
      g = {index_i, ($clog2(CELL_W))'(j)};
      if (bits_q[j]) begin
        tok_d.cnt = '0;
      end else begin
        tok_d.cnt = tok_d.cnt + CNT_W'(1);
      end
      if (!tok_d.found && (tok_d.cnt >= need_i)) begin
        tok_d.found = 1'b1;
        tok_d.start = GW'({1'b0, g} + CNT_W'(1) - tok_d.cnt);
      end
    end
  end

  always_comb begin
    logic [POS_W-1:0] gp;
    bits_d = bits_q;
    for (int j = 0; j < CELL_W; j++) begin
      gp = POS_W'({index_i, ($clog2(CELL_W))'(j)});
      if (upd_i.en && (gp >= upd_i.lo) && (gp < upd_i.hi)) begin
        bits_d[j] = upd_i.set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      tok_q     <= '0;
    end else begin
      bits_q    <= bits_d;
      tok_q     <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hw/rtl/bitmap_first_fit_allocator.sv */
// First-fit heap allocator over 1024 four-byte granules. Start an item with
// start high while busy is low; its one result appears on rsp_o for a single
// cycle with done_o high and must be taken then, the block cannot be stalled.
// An allocate sends a scan token down a row of 128 cells of 8 granules each,
// one cell per cycle; a zero-byte allocate fails without a scan and a free
// answers after one length-memory read. The bitmap is cleared at reset;
// region_q, the region limit in bytes, is written through cfg_we_i.
module bitmap_first_fit_allocator
  import bffa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output rsp_t              rsp_o,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] region_q;
  logic [CNT_W-1:0]  need_q, need_d;
  logic              inject_q, inject_d;
  logic [CNT_W-1:0]  fstart_q, fstart_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic [CNT_W-1:0]  len_mem [GRANULES];
  logic [CNT_W-1:0]  rd_q;
  logic              rd_en, wr_en;
  logic [GW-1:0]     wr_addr;
  logic [CNT_W-1:0]  wr_data;

  token_t            chain [CELLS+1];
  upd_t              upd;

  logic              accept;
  logic [NEED_W-1:0] need_full;
  logic [ADDR_W-1:0] faddr;
  token_t            tok_end;
  logic [POS_W-1:0]  end_sum;
  logic [CNT_W-1:0]  len;

  assign accept    = start && !busy;
  assign need_full = NEED_W'((({1'b0, req_i.request_bytes}) + (REQ_W+1)'(3)) >> 2)
                     + NEED_W'(1);
  assign faddr     = req_i.block_address - ADDR_W'(4);
  assign tok_end   = chain[CELLS];
  assign end_sum   = POS_W'(tok_end.start) + POS_W'(need_q);
  assign len       = (fstart_q < CNT_W'(GRANULES)) ? rd_q : '0;

  assign chain[0] = '{valid: inject_q, found: 1'b0, cnt: '0, start: '0};

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    bffa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .index_i(CW'(k)),
      .need_i (need_q),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1]),
      .upd_i  (upd)
    );
  end

  always_comb begin
    state_d  = state_q;
    need_d   = need_q;
    inject_d = 1'b0;
    fstart_d = fstart_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    upd      = '0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = tok_end.start;
    wr_data  = need_q;
    busy     = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.mode == MODE_FREE) begin
            fstart_d = faddr[ADDR_W-1:2];
            rd_en    = 1'b1;
            state_d  = ST_FREE;
          end else if (req_i.request_bytes == '0) begin
            done_d = 1'b1;
            rsp_d  = '{failed: 1'b1, granted_address: '0};
          end else begin
            // clamp: any need above the map size can never fit
            need_d   = (need_full > NEED_W'(GRANULES + 1)) ? CNT_W'(GRANULES + 1)
                                                          : CNT_W'(need_full);
            inject_d = 1'b1;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok_end.valid) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (tok_end.found && ({end_sum, 2'b00} < (POS_W+2)'(region_q))) begin
            upd   = '{en: 1'b1, set: 1'b1, lo: POS_W'(tok_end.start), hi: end_sum};
            wr_en = 1'b1;
            rsp_d = '{failed: 1'b0,
                      granted_address: ADDR_W'({tok_end.start, 2'b00}) + ADDR_W'(4)};
          end else begin
            rsp_d = '{failed: 1'b1, granted_address: '0};
          end
        end
      end
      ST_FREE: begin
        upd     = '{en: 1'b1, set: 1'b0, lo: POS_W'(fstart_q),
                    hi: POS_W'(fstart_q) + POS_W'(len)};
        done_d  = 1'b1;
        rsp_d   = '{failed: 1'b0, granted_address: '0};
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      region_q <= RegionReset;
      inject_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      inject_q <= inject_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        region_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    fstart_q <= fstart_d;
    rsp_q    <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      len_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= len_mem[fstart_d[GW-1:0]];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* tb/sv/bitmap_first_fit_allocator_tb.sv */
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_tb
  import bffa_pkg::*;
;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  req_t              req_i = '0;
  logic              done_o;
  rsp_t              rsp_o;
  logic              cfg_we_i = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i = '0;

  bitmap_first_fit_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow heap state
  bit                granule_used[GRANULES];
  logic [10:0]       granule_len[GRANULES];
  bit                len_valid[GRANULES];
  logic [ADDR_W-1:0] region_limit = RegionReset;

  rsp_t              expected_rsp[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int                mismatches = 0;
  int                idle_pct = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int header_granule(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] hdr;
    hdr = addr - ADDR_W'(4);
    return int'(hdr) / 4;
  endfunction

  function automatic rsp_t heap_step(req_t r);
    rsp_t o;
    int   total;
    int   need;
    int   cnt;
    int   first;
    int   base;
    int   len;
    bit   hit;
    o = '0;
    if (r.mode == MODE_ALLOC) begin
      if (r.request_bytes == '0) begin
        o.failed = 1'b1;
        return o;
      end
      total = ((int'(r.request_bytes) + 3) & ~3) + 4;
      need  = total / 4;
      cnt   = 0;
      hit   = 1'b0;
      first = 0;
      for (int g = 0; g < GRANULES && !hit; g++) begin
        cnt = granule_used[g] ? 0 : cnt + 1;
        if (cnt >= need) begin
          hit   = 1'b1;
          first = g + 1 - cnt;
        end
      end
      if (!hit || first * 4 + total >= int'(region_limit)) begin
        o.failed = 1'b1;
      end else begin
        for (int i = 0; i < need; i++) granule_used[first + i] = 1'b1;
        granule_len[first] = 11'(need);
        len_valid[first] = 1'b1;
        o.granted_address = ADDR_W'(first * 4 + 4);
        live_blocks.push_back(o.granted_address);
      end
    end else begin
      base = header_granule(r.block_address);
      len  = (base < GRANULES) ? int'(granule_len[base]) : 0;
      for (int i = 0; i < len; i++) begin
        if (base + i < GRANULES) granule_used[base + i] = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic bit free_is_defined(logic [ADDR_W-1:0] addr);
    int base;
    base = header_granule(addr);
    return base >= GRANULES || len_valid[base];
  endfunction

  function automatic req_t alloc_item(int bytes);
    req_t r;
    r.mode          = MODE_ALLOC;
    r.request_bytes = REQ_W'(bytes);
    r.block_address = ADDR_W'($urandom_range(0, 4096));
    return r;
  endfunction

  function automatic req_t free_item(logic [ADDR_W-1:0] addr);
    req_t r;
    r.mode          = MODE_FREE;
    r.request_bytes = REQ_W'($urandom);
    r.block_address = addr;
    return r;
  endfunction

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result failed=%0d addr=%0d",
                                       rsp_o.failed, rsp_o.granted_address);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_o.failed !== want.failed ||
            rsp_o.granted_address !== want.granted_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected failed=%0d addr=%0d, got failed=%0d addr=%0d",
                     want.failed, want.granted_address,
                     rsp_o.failed, rsp_o.granted_address);
        end
      end
    end
  end

  task automatic send_item(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_rsp.push_back(heap_step(r));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  // hold off until every prediction has been matched
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_region(logic [ADDR_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    region_limit = v;
    @(posedge clk_i);
  endtask

  task automatic test_directed;
    send_item(alloc_item(0));
    send_item(alloc_item(1));
    send_item(alloc_item(65535));
    send_item(alloc_item(5));
    send_item(free_item(ADDR_W'(4)));
    send_item(free_item(ADDR_W'(4)));
    send_item(free_item(ADDR_W'(0)));
    send_item(free_item(ADDR_W'(3)));
    send_item(free_item(ADDR_W'(2)));
    send_item(alloc_item(4));
    send_item(free_item(ADDR_W'(7)));
    repeat (5) send_item(alloc_item(1000));
    send_item(alloc_item(4089));
    while (live_blocks.size() != 0) send_item(free_item(live_blocks.pop_front()));
    send_item(alloc_item(4088));
    send_item(free_item(live_blocks.pop_front()));
  endtask

  task automatic test_region_extremes;
    write_region(ADDR_W'(8));
    send_item(alloc_item(1));
    write_region(ADDR_W'(12));
    send_item(alloc_item(1));
    send_item(alloc_item(1));
    send_item(free_item(live_blocks.pop_front()));
    write_region(ADDR_W'(8191));
    send_item(alloc_item(4088));
    send_item(free_item(live_blocks.pop_front()));
    write_region(ADDR_W'(4096));
  endtask

  task automatic test_random(int count, int pct);
    int                sel;
    int                bytes;
    int                idx;
    int                k;
    logic [ADDR_W-1:0] addr;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 75) drain();
      if (live_blocks.size() == 0 || $urandom_range(99) < 52) begin
        sel = $urandom_range(99);
        if (sel < 3) bytes = 0;
        else if (sel < 70) bytes = $urandom_range(1, 32);
        else if (sel < 90) bytes = $urandom_range(33, 512);
        else if (sel < 97) bytes = $urandom_range(513, 4100);
        else bytes = $urandom_range(0, 65535);
        send_item(alloc_item(bytes));
      end else if ($urandom_range(99) < 85) begin
        idx  = $urandom_range(0, live_blocks.size() - 1);
        addr = live_blocks[idx];
        live_blocks.delete(idx);
        k = $urandom_range(0, 3);
        if (int'(addr) + k <= 4096) addr = addr + ADDR_W'(k);
        send_item(free_item(addr));
      end else begin
        // stale, double or out-of-map free
        do addr = ADDR_W'($urandom_range(0, 4096)); while (!free_is_defined(addr));
        send_item(free_item(addr));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_region_extremes();
    test_random(600, 13);
    write_region(ADDR_W'($urandom_range(8, 4096)));
    test_random(550, 85);
    write_region(ADDR_W'($urandom_range(2048, 8191)));
    test_random(600, 0);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_cell.sv
hw/rtl/bitmap_first_fit_allocator.sv
tb/sv/bitmap_first_fit_allocator_tb.sv
